FILE: design/gmx_pkg.sv
// Shared types, constants and codes for the group minimum xmin table.
package gmx_pkg;

  localparam int RELATION_SLOTS  = 8;
  localparam int SEGMENT_COUNT   = 16;
  localparam int GROUP_COUNT     = 64;
  localparam int PAGES_PER_GROUP = 1024;

  localparam int DATA_W    = 32;
  localparam int SLOT_W    = $clog2(RELATION_SLOTS);
  localparam int GRP_W     = $clog2(GROUP_COUNT);
  localparam int PPG_SHIFT = $clog2(PAGES_PER_GROUP);
  localparam int MAP_DEPTH = RELATION_SLOTS * SEGMENT_COUNT * GROUP_COUNT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  // Address strides of one slot and one segment in the map.
  localparam int SLOT_STRIDE = SEGMENT_COUNT * GROUP_COUNT;
  localparam int SEG_STRIDE  = GROUP_COUNT;

  // Range limits, one bit wider than the field they are compared against.
  localparam logic [8:0]  SEG_LIMIT  = 9'(SEGMENT_COUNT);
  localparam logic [32:0] PAGE_LIMIT = 33'(longint'(GROUP_COUNT) * longint'(PAGES_PER_GROUP));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_GET = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] relation_id;
    logic [7:0]        segment;
    logic [DATA_W-1:0] page;
    logic [DATA_W-1:0] xmin_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] group_minimum;
    logic [1:0]        status;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [1:0]        status;
    logic              action;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] xmin;
  } cmd_t;

  // Queue side toward the back.
  typedef struct packed {
    logic valid;
    cmd_t head;
  } queue_out_t;

endpackage

FILE: design/gmx_front.sv
// Front: range check, relation slot lookup and claim, map address build.
module gmx_front import gmx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  logic     q_full,
  input  logic     clearing,
  output logic     in_stall,
  output logic     push,
  output cmd_t     cmd
);

  logic [DATA_W-1:0]         slots [RELATION_SLOTS];
  logic [RELATION_SLOTS-1:0] hit;
  logic                      found;
  logic [SLOT_W-1:0]         slot;
  logic                      range_ok;
  logic [GRP_W-1:0]          group;

  always_comb begin
    for (int i = 0; i < RELATION_SLOTS; i++) begin
      hit[i] = (slots[i] == in_item.relation_id) || (slots[i] == '0);
    end
  end

  // First slot that matches or is empty wins.
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = RELATION_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
  end

  assign range_ok = ({1'b0, in_item.segment} < SEG_LIMIT) &&
                    ({1'b0, in_item.page} < PAGE_LIMIT);
  assign group    = GRP_W'(in_item.page >> PPG_SHIFT);

  always_comb begin
    if (!range_ok) begin
      cmd.status = STATUS_RANGE;
    end else if (!found) begin
      cmd.status = STATUS_FULL;
    end else begin
      cmd.status = STATUS_OK;
    end
    cmd.action = in_item.action;
    cmd.xmin   = in_item.xmin_value;
    cmd.addr   = ADDR_W'(slot) * ADDR_W'(SLOT_STRIDE)
               + ADDR_W'(in_item.segment) * ADDR_W'(SEG_STRIDE)
               + ADDR_W'(group);
  end

  assign in_stall = clearing || q_full;
  assign push     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RELATION_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (push && cmd.status == STATUS_OK) begin
      slots[slot] <= in_item.relation_id;
    end
  end

  // An accepted good request leaves its slot holding its relation id.
  a_slot_claimed: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.status == STATUS_OK) |=> slots[$past(slot)] == $past(in_item.relation_id))
    else $error("slot does not hold the relation after lookup");

endmodule

FILE: design/gmx_queue.sv
// Short in-order queue of classified requests between front and back.
module gmx_queue import gmx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output logic       full,
  output queue_out_t q_out
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full         = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_out.valid  = (count != '0);
  assign q_out.head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_out.valid)
    else $error("pop from empty queue");

endmodule

FILE: design/gmx_back.sv
// Back: map memory with clearing pass, read-modify-write merge, result register.
module gmx_back import gmx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  queue_out_t q_out,
  output logic       pop,
  output logic       clearing,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_item
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } back_state_t;

  logic [DATA_W-1:0] mem [MAP_DEPTH];

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  cmd_t              cur;
  logic [DATA_W-1:0] rd_data;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic              out_free;
  logic              load;
  out_item_t         load_item;
  logic              take_new;
  logic [DATA_W-1:0] merged;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || !out_stall;

  assign take_new = (cur.action == ACT_SET) && ((rd_data == '0) || (cur.xmin < rd_data));
  assign merged   = take_new ? cur.xmin : rd_data;

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur.addr;
    mem_wdata  = merged;
    mem_re     = 1'b0;
    pop        = 1'b0;
    load       = 1'b0;
    load_item  = '{group_minimum: merged, status: STATUS_OK};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == ADDR_W'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_out.valid) begin
          if (q_out.head.status != STATUS_OK) begin
            // Errors touch nothing: report as soon as the output is free.
            if (out_free) begin
              pop       = 1'b1;
              load      = 1'b1;
              load_item = '{group_minimum: '0, status: q_out.head.status};
            end
          end else begin
            pop        = 1'b1;
            mem_re     = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          mem_we     = (cur.action == ACT_SET);
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[q_out.head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_out.head;
    end
    if (load) begin
      out_item <= load_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !pop))
    else $error("activity during clearing pass");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && out_free) |=> (out_valid && out_item.status == STATUS_OK))
    else $error("read did not produce a result");

  a_set_not_larger: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && out_free && cur.action == ACT_SET && rd_data != '0)
      |=> (out_item.group_minimum <= $past(rd_data)))
    else $error("set raised a stored minimum");

endmodule

FILE: design/group_min_xmin_table_top.sv
// Top level of the group minimum xmin table: front, queue and back.
//
// Usage:
//   in_valid/in_stall/in_item carry requests: a set or get of the minimum
//   xmin for a relation, segment and page. A request is taken at a rising
//   edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_item carry one result per request, in order:
//   the entry value after the step plus a status (ok, table full, range).
// Flow:
//   The front classifies a request in the cycle it is taken (range check,
//   parallel slot compare, slot claim) and pushes it into a 2-entry queue.
//   The back does one map read, then merge and write-back, so a good
//   request passes through ST_IDLE and ST_READ, while an error is
//   reported from ST_IDLE alone. The back takes no new request until the
//   current one is done, as the map memory has a single port pair.
// Reset:
//   rst clears the slot table at once, then the back sweeps all 8192 map
//   entries to zero, one per cycle; in_stall stays high for those cycles.
// Stall:
//   A result holds in the output register while out_stall is high; the
//   queue keeps taking requests until it fills, then in_stall rises.
module group_min_xmin_table_top import gmx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic       push;
  cmd_t       cmd;
  logic       q_full;
  logic       pop;
  logic       clearing;
  queue_out_t q_out;

  // Classify and claim slots; hold off while the map is being cleared.
  gmx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .clearing (clearing),
    .in_stall (in_stall),
    .push     (push),
    .cmd      (cmd)
  );

  // Decouple front from back so each side can stall on its own.
  gmx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (q_full),
    .q_out    (q_out)
  );

  // Read-modify-write the map and drive the result register.
  gmx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_out     (q_out),
    .pop       (pop),
    .clearing  (clearing),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
